// File: rtl/gasp_pkg.sv
// package for the grid a* path search block
// action codes, cell kinds, step costs, config indexes, grid size defaults and a saturating add; no dependencies
package gasp_pkg;

  localparam int MaxRowsDef = 32;
  localparam int MaxColsDef = 32;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_SEARCH = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [1:0] KIND_SPACE = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TARGET = 2'd2;
  localparam logic [1:0] KIND_OBSTACLE = 2'd3;

  localparam logic [4:0] STEP_STRAIGHT = 5'd10;
  localparam logic [4:0] STEP_DIAGONAL = 5'd14;

  localparam logic [0:0] CFG_ROWS = 1'd0;
  localparam logic [0:0] CFG_COLS = 1'd1;

  // saturating 16-bit add
  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [16:0] b);
    logic [17:0] s;
    s = {2'b0, a} + {1'b0, b};
    sat_add = (s > 18'd65535) ? 16'hffff : s[15:0];
  endfunction

endpackage

// File: rtl/grid_astar_path_search.sv
// grid a* path search, top level: command port, cell stores and search sequencer
// depends on gasp_pkg
// a cell write or parent read goes through S_WR or S_RESP before done, busy high for a single cycle;
// an out-of-range or unknown command answers straight from idle with busy low.
// search: a mark clearing pass of one cycle per store entry plus a set-up state, then per
// expansion a scan of every open entry, a move up of the entries behind the picked one,
// the expanded cell and each neighbor. reset (rst, synchronous) clears control state,
// then a pass of one cycle per store entry (1024 by default) clears the cell and mark
// stores with busy high. the receiver cannot stall.
module grid_astar_path_search #(
  parameter int MAX_ROWS = gasp_pkg::MaxRowsDef,
  parameter int MAX_COLS = gasp_pkg::MaxColsDef
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] action,
  input  logic [4:0] cell_row,
  input  logic [4:0] cell_col,
  input  logic [1:0] cell_kind,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [5:0] cfg_data,
  output logic       done,
  output logic       path_found,
  output logic [15:0] path_cost,
  output logic [4:0] parent_row,
  output logic [4:0] parent_col,
  output logic       parent_valid
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int NW = AW + 1;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_WR     = 14'b00000000000100,
    S_SCLR   = 14'b00000000001000,
    S_INIT   = 14'b00000000010000,
    S_SCAN   = 14'b00000000100000,
    S_SCANF  = 14'b00000001000000,
    S_PICK   = 14'b00000010000000,
    S_SHIFT  = 14'b00000100000000,
    S_SHW    = 14'b00001000000000,
    S_CUR    = 14'b00010000000000,
    S_NB     = 14'b00100000000000,
    S_NBUPD  = 14'b01000000000000,
    S_RESP   = 14'b10000000000000
  } state_t;

  // per cell record: kind, parent valid flag, parent, g, f in one wide word
  typedef struct packed {
    logic [1:0]    kind;
    logic          pvalid;
    logic [AW-1:0] parent;
    logic [15:0]   g;
    logic [15:0]   f;
  } cell_t;

  cell_t cell_mem [DEPTH];
  logic [1:0] mark_mem [DEPTH]; // {open, closed}
  logic [AW-1:0] olist_mem [DEPTH];

  state_t state;
  logic [5:0] rows_in_use, cols_in_use;
  logic [AW-1:0] start_cell, target_cell;
  logic [NW-1:0] open_count, idx, best_idx, sh_idx;
  logic [AW-1:0] best_cell, cur;
  logic [15:0] best_f, cur_g;
  logic [2:0] nb;
  logic [AW-1:0] ncell;
  logic ndiag;
  logic [AW:0] clr_addr;
  logic [AW-1:0] wr_addr;
  logic [1:0] wr_kind;

  // memory ports
  logic cm_we; logic [AW-1:0] cm_waddr, cm_raddr; cell_t cm_wdata, cm_rdata;
  logic mm_we; logic [AW-1:0] mm_waddr, mm_raddr; logic [1:0] mm_wdata, mm_rdata;
  logic ol_we; logic [AW-1:0] ol_waddr, ol_raddr, ol_wdata, ol_rdata;

  always_ff @(posedge clk) begin
    if (cm_we) cell_mem[cm_waddr] <= cm_wdata;
    cm_rdata <= cell_mem[cm_raddr];
    if (mm_we) mark_mem[mm_waddr] <= mm_wdata;
    mm_rdata <= mark_mem[mm_raddr];
    if (ol_we) olist_mem[ol_waddr] <= ol_wdata;
    ol_rdata <= olist_mem[ol_raddr];
  end

  // clamped grid limits
  logic [8:0] rows_lim, cols_lim;
  always_comb begin
    rows_lim = (rows_in_use == 6'd0) ? 9'd1 : {3'b0, rows_in_use};
    if (rows_lim > 9'(MAX_ROWS)) rows_lim = 9'(MAX_ROWS);
    cols_lim = (cols_in_use == 6'd0) ? 9'd1 : {3'b0, cols_in_use};
    if (cols_lim > 9'(MAX_COLS)) cols_lim = 9'(MAX_COLS);
  end

  // heuristic against target
  function automatic logic [15:0] heur(input logic [AW-1:0] c, input logic [AW-1:0] t);
    logic [RW-1:0] r, tr; logic [CW-1:0] cc, tc; logic [15:0] dr, dc;
    r = c[AW-1:CW]; cc = c[CW-1:0]; tr = t[AW-1:CW]; tc = t[CW-1:0];
    dr = (r > tr) ? 16'(r - tr) : 16'(tr - r);
    dc = (cc > tc) ? 16'(cc - tc) : 16'(tc - cc);
    heur = dr + dc;
  endfunction

  // neighbour coordinates
  logic signed [9:0] nrow, ncol;
  logic nb_ok;
  always_comb begin
    nrow = $signed({1'b0, 9'(cur[AW-1:CW])});
    ncol = $signed({1'b0, 9'(cur[CW-1:0])});
    case (nb)
      3'd0: begin nrow = nrow - 10'sd1; ncol = ncol - 10'sd1; end
      3'd1: begin nrow = nrow - 10'sd1; end
      3'd2: begin nrow = nrow - 10'sd1; ncol = ncol + 10'sd1; end
      3'd3: begin ncol = ncol + 10'sd1; end
      3'd4: begin ncol = ncol - 10'sd1; end
      3'd5: begin nrow = nrow + 10'sd1; ncol = ncol - 10'sd1; end
      3'd6: begin nrow = nrow + 10'sd1; end
      default: begin nrow = nrow + 10'sd1; ncol = ncol + 10'sd1; end
    endcase
    nb_ok = (nrow >= 0) && (ncol >= 0) && (nrow < $signed({1'b0, rows_lim}))
            && (ncol < $signed({1'b0, cols_lim}));
  end

  logic in_range;
  logic [AW-1:0] in_cell;
  assign in_range = (32'(cell_row) < MAX_ROWS) && (32'(cell_col) < MAX_COLS);
  assign in_cell = {RW'(cell_row), CW'(cell_col)};
  logic accept;
  assign accept = start && !busy;
  assign busy = (state != S_IDLE);

  logic [16:0] cand;
  assign cand = {1'b0, cur_g} + {12'b0, (ndiag ? gasp_pkg::STEP_DIAGONAL
                                                : gasp_pkg::STEP_STRAIGHT)};

  // open list scan: first entry with the lowest f wins
  logic take;
  assign take = (cm_rdata.f < best_f) || (idx == '0);

  // memory port drive
  always_comb begin
    cm_we = 1'b0; cm_waddr = cur; cm_wdata = cm_rdata; cm_raddr = in_cell;
    mm_we = 1'b0; mm_waddr = cur; mm_wdata = 2'b00; mm_raddr = ncell;
    ol_we = 1'b0; ol_waddr = idx[AW-1:0]; ol_wdata = cur; ol_raddr = idx[AW-1:0];
    case (state)
      S_CLEAR: begin
        cm_we = 1'b1; cm_waddr = clr_addr[AW-1:0];
        cm_wdata = '0;
        mm_we = 1'b1; mm_waddr = clr_addr[AW-1:0];
      end
      S_WR: begin
        cm_we = 1'b1; cm_waddr = wr_addr;
        cm_wdata = cm_rdata; cm_wdata.kind = wr_kind;
      end
      S_SCLR: begin
        mm_we = 1'b1; mm_waddr = clr_addr[AW-1:0];
        cm_raddr = start_cell;
      end
      S_INIT: begin
        cm_we = 1'b1; cm_waddr = start_cell;
        cm_wdata = cm_rdata; cm_wdata.pvalid = 1'b0; cm_wdata.g = '0;
        cm_wdata.f = heur(start_cell, target_cell);
        mm_we = 1'b1; mm_waddr = start_cell; mm_wdata = 2'b10;
        ol_we = 1'b1; ol_waddr = '0; ol_wdata = start_cell;
      end
      S_SCAN: begin
        ol_raddr = idx[AW-1:0];
      end
      S_SCANF: begin
        cm_raddr = ol_rdata;
      end
      S_SHIFT: begin
        ol_raddr = sh_idx[AW-1:0];
        cm_raddr = cur;
      end
      S_SHW: begin
        ol_we = 1'b1; ol_waddr = AW'(sh_idx - 1'b1); ol_wdata = ol_rdata;
      end
      S_CUR: begin
        mm_we = 1'b1; mm_waddr = cur; mm_wdata = 2'b01;
        cm_raddr = cur;
      end
      S_NB: begin
        cm_raddr = AW'({nrow[RW-1:0], ncol[CW-1:0]});
        mm_raddr = AW'({nrow[RW-1:0], ncol[CW-1:0]});
      end
      S_NBUPD: begin
        cm_waddr = ncell; mm_waddr = ncell;
        if (cm_rdata.kind != gasp_pkg::KIND_OBSTACLE && !mm_rdata[0] &&
            (!mm_rdata[1] || cand < {1'b0, cm_rdata.g})) begin
          cm_we = 1'b1;
          cm_wdata.pvalid = 1'b1; cm_wdata.parent = cur;
          cm_wdata.g = gasp_pkg::sat_add(16'd0, cand);
          cm_wdata.f = gasp_pkg::sat_add(cm_wdata.g, {1'b0, heur(ncell, target_cell)});
          if (!mm_rdata[1]) begin
            mm_we = 1'b1; mm_wdata = 2'b10;
            ol_we = 1'b1; ol_waddr = open_count[AW-1:0]; ol_wdata = ncell;
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR; clr_addr <= '0; rows_in_use <= 6'd32; cols_in_use <= 6'd32;
      start_cell <= '0; target_cell <= '0; done <= 1'b0; open_count <= '0;
      path_found <= 1'b0; path_cost <= '0; parent_row <= '0; parent_col <= '0;
      parent_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == gasp_pkg::CFG_ROWS) rows_in_use <= cfg_data;
        else cols_in_use <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (AW+1)'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            path_found <= 1'b0; path_cost <= '0; parent_row <= '0; parent_col <= '0;
            parent_valid <= 1'b0;
            if (action == gasp_pkg::ACT_SEARCH) begin
              clr_addr <= '0; state <= S_SCLR;
            end else if (action == gasp_pkg::ACT_WRITE && in_range) begin
              wr_addr <= in_cell; wr_kind <= cell_kind;
              if (cell_kind == gasp_pkg::KIND_START) start_cell <= in_cell;
              else if (cell_kind == gasp_pkg::KIND_TARGET) target_cell <= in_cell;
              state <= S_WR;
            end else if (action == gasp_pkg::ACT_READ && in_range) begin
              state <= S_RESP;
            end else begin
              done <= 1'b1;
            end
          end
        end
        S_WR: begin
          done <= 1'b1; state <= S_IDLE;
        end
        S_SCLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (AW+1)'(DEPTH - 1)) state <= S_INIT;
        end
        S_INIT: begin
          open_count <= NW'(1); idx <= '0; best_f <= 16'hffff; best_idx <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (open_count == '0) begin
            done <= 1'b1; path_found <= 1'b0; path_cost <= '0; state <= S_IDLE;
          end else state <= S_SCANF;
        end
        S_SCANF: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (take) begin
            best_f <= cm_rdata.f; best_idx <= idx; best_cell <= ol_rdata;
          end
          if (idx + 1'b1 < open_count) begin
            idx <= idx + 1'b1; state <= S_SCAN;
          end else begin
            cur <= take ? ol_rdata : best_cell;
            sh_idx <= (take ? idx : best_idx) + 1'b1;
            state <= S_SHIFT;
          end
        end
        // move the entries behind the picked one up by one place
        S_SHIFT: begin
          if (sh_idx < open_count) state <= S_SHW;
          else state <= S_CUR;
        end
        S_SHW: begin
          sh_idx <= sh_idx + 1'b1; state <= S_SHIFT;
        end
        S_CUR: begin
          open_count <= open_count - 1'b1;
          cur_g <= cm_rdata.g;
          if (cm_rdata.kind == gasp_pkg::KIND_TARGET) begin
            done <= 1'b1; path_found <= 1'b1; path_cost <= cm_rdata.g; state <= S_IDLE;
          end else begin
            nb <= 3'd0; state <= S_NB;
          end
        end
        S_NB: begin
          ncell <= AW'({nrow[RW-1:0], ncol[CW-1:0]});
          ndiag <= (nb != 3'd1) && (nb != 3'd3) && (nb != 3'd4) && (nb != 3'd6);
          if (nb_ok) state <= S_NBUPD;
          else if (nb == 3'd7) begin idx <= '0; best_f <= 16'hffff; state <= S_SCAN; end
          else nb <= nb + 1'b1;
        end
        S_NBUPD: begin
          if (mm_we && mm_wdata == 2'b10) open_count <= open_count + 1'b1;
          if (nb == 3'd7) begin idx <= '0; best_f <= 16'hffff; state <= S_SCAN; end
          else begin nb <= nb + 1'b1; state <= S_NB; end
        end
        S_RESP: begin
          done <= 1'b1; parent_valid <= cm_rdata.pvalid;
          parent_row <= cm_rdata.pvalid ? 5'(cm_rdata.parent[AW-1:CW]) : '0;
          parent_col <= cm_rdata.pvalid ? 5'(cm_rdata.parent[CW-1:0]) : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_busy_done;
    @(posedge clk) disable iff (rst) (done && state == S_IDLE) |-> !busy;
  endproperty
  a_busy_done: assert property (p_busy_done) else $error("done while busy");
  a_read_one: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_RESP) |=> done) else $error("read answer missing");
  a_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_NB) |-> (open_count <= NW'(DEPTH))) else $error("open list overflow");

endmodule

// File: bench/grid_astar_path_search_check.sv
// checker for the grid a* path search block: watches the command, config and result ports,
// predicts every result and compares it field by field; depends on gasp_pkg
`timescale 1ns / 100ps
module grid_astar_path_search_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  action,
  input  logic [4:0]  cell_row,
  input  logic [4:0]  cell_col,
  input  logic [1:0]  cell_kind,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [5:0]  cfg_data,
  input  logic        done,
  input  logic        path_found,
  input  logic [15:0] path_cost,
  input  logic [4:0]  parent_row,
  input  logic [4:0]  parent_col,
  input  logic        parent_valid,
  output int          errors,
  output int          pending
);

  localparam int NumCells = gasp_pkg::MaxRowsDef * gasp_pkg::MaxColsDef;

  typedef struct packed {
    logic        found;
    logic [15:0] cost;
    logic [4:0]  prow;
    logic [4:0]  pcol;
    logic        pvalid;
  } answer_t;

  // mirror of the grid and search state
  logic [1:0]  kinds [NumCells];
  bit          link_ok [NumCells];
  int          link_cell [NumCells];
  logic [15:0] g_cost [NumCells];
  logic [15:0] f_cost [NumCells];
  bit          closed_mark [NumCells];
  bit          open_mark [NumCells];
  int          open_cells [$];
  int          start_at;
  int          target_at;
  logic [5:0]  rows_reg;
  logic [5:0]  cols_reg;
  answer_t     answers_due [$];

  function automatic int clamp_dim(input logic [5:0] v, input int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : int'(v);
  endfunction

  function automatic int dist_to_target(input int spot);
    int dr;
    int dc;
    dr = spot / gasp_pkg::MaxColsDef - target_at / gasp_pkg::MaxColsDef;
    dc = spot % gasp_pkg::MaxColsDef - target_at % gasp_pkg::MaxColsDef;
    return (dr < 0 ? -dr : dr) + (dc < 0 ? -dc : dc);
  endfunction

  function automatic logic [15:0] sat16(input int unsigned v);
    return (v > 65535) ? 16'hffff : v[15:0];
  endfunction

  // a* walk over the mirrored grid
  function automatic void walk_grid(output logic found, output logic [15:0] cost);
    int dr [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};
    int dc [8] = '{-1, 0, 1, 1, -1, -1, 0, 1};
    int rows;
    int cols;
    int best;
    int cur;
    int r;
    int c;
    int nr;
    int nc;
    int n;
    int unsigned cand;
    rows = clamp_dim(rows_reg, gasp_pkg::MaxRowsDef);
    cols = clamp_dim(cols_reg, gasp_pkg::MaxColsDef);
    for (int i = 0; i < NumCells; i++) begin
      closed_mark[i] = 0;
      open_mark[i] = 0;
    end
    open_cells.delete();
    g_cost[start_at] = 0;
    f_cost[start_at] = sat16(dist_to_target(start_at));
    link_ok[start_at] = 0;
    open_cells = {open_cells, start_at};
    open_mark[start_at] = 1;
    while (open_cells.size() > 0) begin
      best = 0;
      for (int i = 1; i < open_cells.size(); i++)
        if (f_cost[open_cells[i]] < f_cost[open_cells[best]]) best = i;
      cur = open_cells[best];
      open_cells.delete(best);
      open_mark[cur] = 0;
      closed_mark[cur] = 1;
      if (kinds[cur] == gasp_pkg::KIND_TARGET) begin
        found = 1;
        cost = g_cost[cur];
        return;
      end
      r = cur / gasp_pkg::MaxColsDef;
      c = cur % gasp_pkg::MaxColsDef;
      for (int k = 0; k < 8; k++) begin
        nr = r + dr[k];
        nc = c + dc[k];
        if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
        n = nr * gasp_pkg::MaxColsDef + nc;
        if (kinds[n] == gasp_pkg::KIND_OBSTACLE || closed_mark[n]) continue;
        cand = g_cost[cur] + ((nr != r && nc != c) ? gasp_pkg::STEP_DIAGONAL
                                                  : gasp_pkg::STEP_STRAIGHT);
        if (open_mark[n]) begin
          if (cand >= g_cost[n]) continue;
        end else begin
          open_cells = {open_cells, n};
          open_mark[n] = 1;
        end
        link_ok[n] = 1;
        link_cell[n] = cur;
        g_cost[n] = sat16(cand);
        f_cost[n] = sat16(g_cost[n] + dist_to_target(n));
      end
    end
    found = 0;
    cost = 0;
  endfunction

  // expected answer of one accepted command
  function automatic answer_t grid_answer(input logic [1:0] act, input logic [4:0] row,
                                          input logic [4:0] col, input logic [1:0] kind);
    answer_t a;
    int spot;
    a = '0;
    spot = row * gasp_pkg::MaxColsDef + col;
    if (act == gasp_pkg::ACT_SEARCH) begin
      walk_grid(a.found, a.cost);
    end else if (act == gasp_pkg::ACT_WRITE) begin
      kinds[spot] = kind;
      if (kind == gasp_pkg::KIND_START) start_at = spot;
      else if (kind == gasp_pkg::KIND_TARGET) target_at = spot;
    end else if (act == gasp_pkg::ACT_READ && link_ok[spot]) begin
      a.prow = 5'(link_cell[spot] / gasp_pkg::MaxColsDef);
      a.pcol = 5'(link_cell[spot] % gasp_pkg::MaxColsDef);
      a.pvalid = 1;
    end
    return a;
  endfunction

  // compare results, then take new transfers and config writes
  always @(posedge clk) begin
    answer_t due;
    answer_t fresh;
    int bad;
    if (rst) begin
      for (int i = 0; i < NumCells; i++) begin
        kinds[i] = gasp_pkg::KIND_SPACE;
        link_ok[i] = 0;
        link_cell[i] = 0;
        g_cost[i] = 0;
        f_cost[i] = 0;
        closed_mark[i] = 0;
        open_mark[i] = 0;
      end
      open_cells.delete();
      answers_due.delete();
      start_at = 0;
      target_at = 0;
      rows_reg = 6'd32;
      cols_reg = 6'd32;
      errors <= 0;
      pending <= 0;
    end else begin
      bad = 0;
      if (done) begin
        if (answers_due.size() == 0) begin
          $error("result transfer with nothing expected");
          bad++;
        end else begin
          due = answers_due.pop_front();
          if (path_found !== due.found) begin
            $error("path_found: expected %0d, got %0d", due.found, path_found);
            bad++;
          end
          if (path_cost !== due.cost) begin
            $error("path_cost: expected %0d, got %0d", due.cost, path_cost);
            bad++;
          end
          if (parent_row !== due.prow) begin
            $error("parent_row: expected %0d, got %0d", due.prow, parent_row);
            bad++;
          end
          if (parent_col !== due.pcol) begin
            $error("parent_col: expected %0d, got %0d", due.pcol, parent_col);
            bad++;
          end
          if (parent_valid !== due.pvalid) begin
            $error("parent_valid: expected %0d, got %0d", due.pvalid, parent_valid);
            bad++;
          end
        end
      end
      if (start && !busy) begin
        fresh = grid_answer(action, cell_row, cell_col, cell_kind);
        answers_due = {answers_due, fresh};
      end
      if (cfg_we) begin
        if (cfg_index == gasp_pkg::CFG_ROWS) rows_reg = cfg_data;
        else cols_reg = cfg_data;
      end
      errors <= errors + bad;
      pending <= answers_due.size();
    end
  end

endmodule

// File: bench/grid_astar_path_search_test.sv
// testbench top for the grid a* path search block: clock, reset, directed and random commands
// depends on gasp_pkg, grid_astar_path_search and grid_astar_path_search_check
`timescale 1ns / 100ps
module grid_astar_path_search_test;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  action;
  logic [4:0]  cell_row;
  logic [4:0]  cell_col;
  logic [1:0]  cell_kind;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [5:0]  cfg_data;
  logic        done;
  logic        path_found;
  logic [15:0] path_cost;
  logic [4:0]  parent_row;
  logic [4:0]  parent_col;
  logic        parent_valid;
  int          errors;
  int          pending;

  int burst_left = 0;
  int sent = 0;
  int area_rows = 32;
  int area_cols = 32;

  grid_astar_path_search uut (.*);
  grid_astar_path_search_check checker_i (.*);

  initial clk = 0;
  always #4 clk = ~clk;

  // one command transfer, in bursts with random gaps
  task automatic send(input logic [1:0] a, input int r, input int c, input logic [1:0] k);
    if (burst_left == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1;
    action <= a;
    cell_row <= 5'(r);
    cell_col <= 5'(c);
    cell_kind <= k;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // drain the block, then write both size registers
  task automatic set_area(input logic [5:0] rows, input logic [5:0] cols);
    start <= 0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= gasp_pkg::CFG_ROWS;
    cfg_data <= rows;
    @(posedge clk);
    cfg_index <= gasp_pkg::CFG_COLS;
    cfg_data <= cols;
    @(posedge clk);
    cfg_we <= 0;
    area_rows = (rows == 0) ? 1 :
                (int'(rows) > gasp_pkg::MaxRowsDef ? gasp_pkg::MaxRowsDef : int'(rows));
    area_cols = (cols == 0) ? 1 :
                (int'(cols) > gasp_pkg::MaxColsDef ? gasp_pkg::MaxColsDef : int'(cols));
  endtask

  function automatic int pick_row();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, area_rows - 1);
  endfunction

  function automatic int pick_col();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, area_cols - 1);
  endfunction

  // grid build, search and parent reads with random content
  task automatic random_route();
    int roll;
    repeat ($urandom_range(2, 10)) begin
      roll = $urandom_range(0, 9);
      if (roll == 0)
        send(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31),
             2'($urandom_range(0, 3)));
      else
        send(gasp_pkg::ACT_WRITE, pick_row(), pick_col(),
             (roll < 4) ? gasp_pkg::KIND_OBSTACLE : gasp_pkg::KIND_SPACE);
    end
    send(gasp_pkg::ACT_WRITE, pick_row(), pick_col(), gasp_pkg::KIND_START);
    send(gasp_pkg::ACT_WRITE, pick_row(), pick_col(), gasp_pkg::KIND_TARGET);
    send(gasp_pkg::ACT_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31),
         2'($urandom_range(0, 3)));
    repeat ($urandom_range(1, 4))
      send(gasp_pkg::ACT_READ, pick_row(), pick_col(), 2'($urandom_range(0, 3)));
  endtask

  initial begin
    rst <= 1;
    start <= 0;
    action <= gasp_pkg::ACT_WRITE;
    cell_row <= 0;
    cell_col <= 0;
    cell_kind <= gasp_pkg::KIND_SPACE;
    cfg_we <= 0;
    cfg_index <= gasp_pkg::CFG_ROWS;
    cfg_data <= 0;
    repeat (9) @(posedge clk);
    rst <= 0;

    // single cell area: start alone, then start that is also the target
    set_area(6'd0, 6'd0);
    send(gasp_pkg::ACT_WRITE, 0, 0, gasp_pkg::KIND_START);
    send(gasp_pkg::ACT_SEARCH, 0, 0, gasp_pkg::KIND_SPACE);
    send(gasp_pkg::ACT_WRITE, 0, 0, gasp_pkg::KIND_TARGET);
    send(gasp_pkg::ACT_SEARCH, 0, 0, gasp_pkg::KIND_SPACE);
    send(gasp_pkg::ACT_READ, 0, 0, gasp_pkg::KIND_SPACE);
    send(2'd3, 31, 31, gasp_pkg::KIND_OBSTACLE);
    send(gasp_pkg::ACT_WRITE, 31, 31, gasp_pkg::KIND_OBSTACLE);
    send(gasp_pkg::ACT_READ, 31, 31, gasp_pkg::KIND_SPACE);

    // oversized value clamps to the full grid; route in the far corner
    set_area(6'd63, 6'd63);
    send(gasp_pkg::ACT_WRITE, 31, 30, gasp_pkg::KIND_START);
    send(gasp_pkg::ACT_WRITE, 31, 31, gasp_pkg::KIND_TARGET);
    send(gasp_pkg::ACT_SEARCH, 0, 0, gasp_pkg::KIND_SPACE);
    send(gasp_pkg::ACT_READ, 31, 31, gasp_pkg::KIND_SPACE);
    send(gasp_pkg::ACT_READ, 30, 31, gasp_pkg::KIND_SPACE);
    send(gasp_pkg::ACT_WRITE, 15, 15, gasp_pkg::KIND_SPACE);

    // start outside the area, diagonal step in past an obstacle
    set_area(6'd2, 6'd2);
    send(gasp_pkg::ACT_WRITE, 2, 2, gasp_pkg::KIND_START);
    send(gasp_pkg::ACT_WRITE, 0, 0, gasp_pkg::KIND_TARGET);
    send(gasp_pkg::ACT_WRITE, 1, 0, gasp_pkg::KIND_OBSTACLE);
    send(gasp_pkg::ACT_SEARCH, 0, 0, gasp_pkg::KIND_SPACE);
    send(gasp_pkg::ACT_READ, 1, 1, gasp_pkg::KIND_SPACE);
    send(gasp_pkg::ACT_READ, 0, 0, gasp_pkg::KIND_SPACE);

    // random phases, mostly small areas
    while (sent < 900) begin
      if ($urandom_range(0, 6) != 0)
        set_area(6'($urandom_range(1, 8)), 6'($urandom_range(1, 8)));
      else
        set_area($urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(9, 12)),
                 $urandom_range(0, 1) ? 6'd1 : 6'($urandom_range(9, 12)));
      repeat (4) random_route();
    end

    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // run limit
  initial begin
    #400_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
